// ----- hw/rtl/sps_pkg.sv -----
`timescale 1ns / 1ps

package sps_pkg;

  localparam int MAX_PHASES = 8;
  localparam int PHASE_W    = 3;
  localparam int TOTAL_W    = 4;
  localparam int DUR_W      = 28;
  localparam int TIME_W     = 32;
  localparam int CYC_W      = 31;
  localparam int BIT_CNT_W  = 5;

  localparam logic [TIME_W-1:0] DUR_MAX = 32'h0FFF_FFFF;

  localparam logic [1:0] STATUS_OK    = 2'd0;
  localparam logic [1:0] STATUS_RANGE = 2'd1;
  localparam logic [1:0] STATUS_ZERO  = 2'd2;

  typedef enum logic [2:0] {
    KIND_ADVANCE  = 3'd0,
    KIND_SET      = 3'd1,
    KIND_FORCE    = 3'd2,
    KIND_POSITION = 3'd3,
    KIND_OFF2PH   = 3'd4,
    KIND_PH2OFF   = 3'd5,
    KIND_WRITE    = 3'd6,
    KIND_LOAD     = 3'd7
  } kind_t;

  typedef struct packed {
    kind_t               kind;
    logic [PHASE_W-1:0]  phase_index;
    logic [TIME_W-1:0]   operand_value;
    logic [TIME_W-1:0]   now;
  } item_t;

  typedef struct packed {
    logic [TIME_W-1:0]   answer;
    logic [PHASE_W-1:0]  current_phase;
    logic [1:0]          status;
  } result_t;

  typedef struct packed {
    logic capture;
    logic check;
    logic walk_step;
    logic mod_step;
    logic finish;
  } ctl_t;

  typedef struct packed {
    logic need_walk;
    logic need_mod;
    logic walk_done;
  } plan_t;

endpackage

// ----- hw/rtl/sps_controller.sv -----
`timescale 1ns / 1ps

module sps_controller (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  sps_pkg::plan_t plan,
  output logic          busy,
  output sps_pkg::ctl_t ctl
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_WALK,
    S_MOD,
    S_FINISH
  } state_t;

  state_t                        state;
  logic [sps_pkg::BIT_CNT_W-1:0] bit_cnt;

  assign busy = (state != S_IDLE);

  always_comb begin
    ctl = '0;
    case (state)
      S_IDLE:   ctl.capture   = start;
      S_CHECK:  ctl.check     = 1'b1;
      S_WALK:   ctl.walk_step = !plan.walk_done;
      S_MOD:    ctl.mod_step  = 1'b1;
      S_FINISH: ctl.finish    = 1'b1;
      default:  ctl = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      bit_cnt <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (start) state <= S_CHECK;
        end
        S_CHECK: begin
          bit_cnt <= '0;
          state   <= plan.need_walk ? S_WALK : S_FINISH;
        end
        S_WALK: begin
          if (plan.walk_done) state <= plan.need_mod ? S_MOD : S_FINISH;
        end
        S_MOD: begin
          bit_cnt <= bit_cnt + 1'b1;
          if (bit_cnt == sps_pkg::BIT_CNT_W'(sps_pkg::TIME_W - 1)) state <= S_FINISH;
        end
        S_FINISH: state <= S_IDLE;
        default:  state <= S_IDLE;
      endcase
    end
  end

endmodule

// ----- hw/rtl/sps_datapath.sv -----
`timescale 1ns / 1ps

module sps_datapath (
  input  logic             clk,
  input  logic             rst,
  input  sps_pkg::item_t   item,
  input  sps_pkg::ctl_t    ctl,
  output sps_pkg::plan_t   plan,
  output logic             done,
  output sps_pkg::result_t result
);

  localparam int PW = sps_pkg::PHASE_W;
  localparam int TW = sps_pkg::TIME_W;
  localparam int CW = sps_pkg::CYC_W;
  localparam int NW = sps_pkg::TOTAL_W;

  logic [sps_pkg::DUR_W-1:0] dur     [sps_pkg::MAX_PHASES];
  logic [TW-1:0]             last_sw [sps_pkg::MAX_PHASES];
  logic [PW-1:0]             phase_now;
  logic [NW-1:0]             phase_total;
  logic [CW-1:0]             cycle_len;

  sps_pkg::item_t            cmd;
  logic [1:0]                status_q;
  logic [CW-1:0]             acc;
  logic [NW-1:0]             walk_i;
  logic                      found;
  logic [NW-1:0]             found_phase;
  logic [CW-1:0]             rem;
  logic [TW-1:0]             dividend;

  logic [PW-1:0]             idx;
  logic [TW-1:0]             val;
  logic                      idx_bad;
  logic                      load_bad;
  logic [1:0]                chk_status;
  logic                      chk_walk;
  logic [CW-1:0]             t_sum;
  logic [TW-1:0]             shifted;
  logic [TW-1:0]             shifted_sub;
  logic [CW-1:0]             rem_next;
  logic [PW-1:0]             next_adv;
  logic [CW-1:0]             off;
  logic [TW-1:0]             psum;
  logic [TW-1:0]             psum_sub;
  logic [TW-1:0]             pos;
  logic [TW-1:0]             cyc_ext;
  logic [TW-1:0]             fin_answer;
  logic [PW-1:0]             fin_phase;
  logic                      fin_ok;

  assign idx      = cmd.phase_index;
  assign val      = cmd.operand_value;
  assign cyc_ext  = {1'b0, cycle_len};
  assign idx_bad  = {1'b0, idx} >= phase_total;
  assign load_bad = (val == '0) || (val > TW'(sps_pkg::MAX_PHASES)) || (TW'(idx) >= val);
  assign fin_ok   = (status_q == sps_pkg::STATUS_OK);

  always_comb begin
    chk_status = sps_pkg::STATUS_OK;
    chk_walk   = 1'b0;
    case (cmd.kind)
      sps_pkg::KIND_ADVANCE: chk_status = sps_pkg::STATUS_OK;
      sps_pkg::KIND_SET, sps_pkg::KIND_FORCE: begin
        if (idx_bad) chk_status = sps_pkg::STATUS_RANGE;
      end
      sps_pkg::KIND_POSITION: begin
        if (cycle_len == '0) chk_status = sps_pkg::STATUS_ZERO;
        else chk_walk = 1'b1;
      end
      sps_pkg::KIND_OFF2PH: begin
        if (cycle_len == '0) chk_status = sps_pkg::STATUS_ZERO;
        else if (val > cyc_ext) chk_status = sps_pkg::STATUS_RANGE;
        else chk_walk = (val != cyc_ext);
      end
      sps_pkg::KIND_PH2OFF: begin
        if (idx_bad) chk_status = sps_pkg::STATUS_RANGE;
        else chk_walk = 1'b1;
      end
      sps_pkg::KIND_WRITE: begin
        if (val > sps_pkg::DUR_MAX) chk_status = sps_pkg::STATUS_RANGE;
        else chk_walk = 1'b1;
      end
      sps_pkg::KIND_LOAD: begin
        if (load_bad) chk_status = sps_pkg::STATUS_RANGE;
        else chk_walk = 1'b1;
      end
      default: chk_status = sps_pkg::STATUS_OK;
    endcase
  end

  // A load updates the phase count in the check cycle, so the walk reads it back.
  assign plan.need_walk = chk_walk;
  assign plan.need_mod  = (cmd.kind == sps_pkg::KIND_POSITION) && fin_ok;
  assign plan.walk_done = found ||
                          (walk_i == ((cmd.kind == sps_pkg::KIND_POSITION) ? {1'b0, phase_now} :
                                      (cmd.kind == sps_pkg::KIND_PH2OFF) ? {1'b0, idx} :
                                      phase_total));

  assign t_sum       = acc + CW'(dur[walk_i[PW-1:0]]);
  assign shifted     = {rem, dividend[TW-1]};
  assign shifted_sub = shifted - cyc_ext;
  assign rem_next    = (shifted >= cyc_ext) ? shifted_sub[CW-1:0] : shifted[CW-1:0];

  assign next_adv = (({1'b0, phase_now} + 1'b1) == phase_total) ? '0 : phase_now + 1'b1;

  assign off      = (acc == cycle_len) ? '0 : acc;
  assign psum     = {1'b0, off} + {1'b0, rem};
  assign psum_sub = psum - cyc_ext;
  assign pos      = (psum >= cyc_ext) ? psum_sub : psum;

  always_comb begin
    fin_answer = '0;
    fin_phase  = phase_now;
    if (fin_ok) begin
      case (cmd.kind)
        sps_pkg::KIND_ADVANCE: begin
          fin_phase  = next_adv;
          fin_answer = TW'(next_adv);
        end
        sps_pkg::KIND_SET: begin
          fin_phase  = idx;
          fin_answer = TW'(idx);
        end
        sps_pkg::KIND_FORCE: begin
          fin_phase  = idx;
          fin_answer = cmd.now + val;
        end
        sps_pkg::KIND_POSITION: fin_answer = pos;
        sps_pkg::KIND_OFF2PH:   fin_answer = (val == cyc_ext) ? '0 : TW'(found_phase);
        sps_pkg::KIND_PH2OFF:   fin_answer = {1'b0, acc};
        default:                fin_answer = '0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < sps_pkg::MAX_PHASES; i++) begin
        dur[i]     <= '0;
        last_sw[i] <= '0;
      end
      phase_now   <= '0;
      phase_total <= NW'(1);
      cycle_len   <= '0;
      done        <= 1'b0;
    end else begin
      done <= ctl.finish;
      if (ctl.check && chk_status == sps_pkg::STATUS_OK) begin
        if (cmd.kind == sps_pkg::KIND_WRITE) dur[idx] <= val[sps_pkg::DUR_W-1:0];
        if (cmd.kind == sps_pkg::KIND_LOAD) begin
          phase_total <= val[NW-1:0];
          phase_now   <= idx;
        end
      end
      if (ctl.finish && fin_ok) begin
        phase_now <= fin_phase;
        if ((cmd.kind == sps_pkg::KIND_ADVANCE || cmd.kind == sps_pkg::KIND_SET) &&
            fin_phase != phase_now)
          last_sw[fin_phase] <= cmd.now;
        if (cmd.kind == sps_pkg::KIND_WRITE || cmd.kind == sps_pkg::KIND_LOAD)
          cycle_len <= acc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.capture) cmd <= item;
    if (ctl.check) begin
      status_q <= chk_status;
      acc      <= '0;
      walk_i   <= '0;
      found    <= 1'b0;
      rem      <= '0;
      dividend <= cmd.now - last_sw[phase_now];
    end
    if (ctl.walk_step) begin
      acc    <= t_sum;
      walk_i <= walk_i + 1'b1;
      if (cmd.kind == sps_pkg::KIND_OFF2PH) begin
        if ({1'b0, t_sum} > val) begin
          found       <= 1'b1;
          found_phase <= walk_i;
        end else if ({1'b0, t_sum} == val) begin
          found       <= 1'b1;
          found_phase <= walk_i + 1'b1;
        end
      end
    end
    if (ctl.mod_step) begin
      rem      <= rem_next;
      dividend <= {dividend[TW-2:0], 1'b0};
    end
    if (ctl.finish) begin
      result.answer        <= fin_answer;
      result.current_phase <= fin_phase;
      result.status        <= status_q;
    end
  end

endmodule

// ----- hw/rtl/signal_phase_sequencer.sv -----
`timescale 1ns / 1ps

// Fixed-time signal phase sequencer. A command is taken when start is high
// and busy is low; its single result appears on result in the cycle in which
// busy falls, flagged by done for exactly one cycle, and must be captured then.
// Advance, set and force go from the check state straight to finish. Queries and
// table writes walk the duration table one phase per cycle, up to 8 phases;
// a position query then adds a bit-serial remainder.
module signal_phase_sequencer (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  output logic             busy,
  input  sps_pkg::item_t   cmd,
  output logic             done,
  output sps_pkg::result_t result
);

  sps_pkg::ctl_t  ctl;
  sps_pkg::plan_t plan;

  sps_controller u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .plan  (plan),
    .busy  (busy),
    .ctl   (ctl)
  );

  sps_datapath u_dp (
    .clk    (clk),
    .rst    (rst),
    .item   (cmd),
    .ctl    (ctl),
    .plan   (plan),
    .done   (done),
    .result (result)
  );

`ifndef ASSERT_OFF
  a_ctl_onehot: assert property (@(posedge clk) disable iff (rst)
    $onehot0({ctl.capture, ctl.check, ctl.walk_step, ctl.mod_step, ctl.finish}))
    else $error("controller issued overlapping commands");

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("transfer accepted without going busy");

  a_done_after_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> ($past(busy) && !busy))
    else $error("result strobe outside a command");

  a_err_answer: assert property (@(posedge clk) disable iff (rst)
    (done && result.status != sps_pkg::STATUS_OK) |-> (result.answer == '0))
    else $error("nonzero answer on error status");
`endif

endmodule
